// ===== hdl/clcr_pkg.sv =====
// ----------------------------------------------------------------------------
// clcr_pkg
// Shared types and constants for the console line capture ring.
// ----------------------------------------------------------------------------
package clcr_pkg;

  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int BACK_W     = 4;
  localparam int CHAR_W     = 7;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = 5;
  localparam int DROP_W     = 16;
  localparam int GEN_W      = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;

  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_FIN_LO = 8'h40;
  localparam logic [BYTE_W-1:0] CH_FIN_HI = 8'h7e;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3f;
  localparam logic [DROP_W-1:0] DROP_MAX  = 16'hffff;

  typedef enum logic [OP_W-1:0] {
    OP_PUT       = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_READ_LINE = 2'd2,
    OP_READ_PART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ESC_NORMAL = 2'd0,
    ESC_SEEN   = 2'd1,
    ESC_CSI    = 2'd2
  } esc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LWAIT,
    S_LEN,
    S_NULL,
    S_FETCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic take_put;
    logic take_clear;
    logic take_line;
    logic take_part;
    logic load_len;
    logic load_ack;
    logic load_empty;
    logic load_char;
    logic idx_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic miss;
    logic plen_zero;
    logic len_zero;
    logic last_char;
  } dp_stat_t;

endpackage

// ===== hdl/clcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// clcr_ctrl
// Sequencer for item acceptance, line length lookup and character readout.
// ----------------------------------------------------------------------------
module clcr_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [clcr_pkg::OP_W-1:0]   in_opcode,
  output logic                        in_tready,
  input  clcr_pkg::dp_stat_t          st,
  output clcr_pkg::ctrl_cmd_t         cmd
);

  clcr_pkg::state_t state_r;
  clcr_pkg::state_t state_nxt;
  clcr_pkg::op_t    op;
  logic             take;

  assign op   = clcr_pkg::op_t'(in_opcode);
  assign take = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clcr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clcr_pkg::S_IDLE: begin
        if (take) begin
          if (op == clcr_pkg::OP_READ_LINE && !st.miss) begin
            state_nxt = clcr_pkg::S_LWAIT;
          end else if (op == clcr_pkg::OP_READ_PART && !st.plen_zero) begin
            state_nxt = clcr_pkg::S_FETCH;
          end
        end
      end
      clcr_pkg::S_LWAIT: state_nxt = clcr_pkg::S_LEN;
      clcr_pkg::S_LEN: begin
        state_nxt = st.len_zero ? clcr_pkg::S_NULL : clcr_pkg::S_FETCH;
      end
      clcr_pkg::S_NULL: begin
        if (st.out_free) begin
          state_nxt = clcr_pkg::S_IDLE;
        end
      end
      clcr_pkg::S_FETCH: state_nxt = clcr_pkg::S_EMIT;
      clcr_pkg::S_EMIT: begin
        if (st.out_free) begin
          state_nxt = st.last_char ? clcr_pkg::S_IDLE : clcr_pkg::S_FETCH;
        end
      end
      default: state_nxt = clcr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      clcr_pkg::S_IDLE: begin
        in_tready = st.out_free;
        if (take) begin
          unique case (op)
            clcr_pkg::OP_PUT: begin
              cmd.take_put = 1'b1;
              cmd.load_ack = 1'b1;
            end
            clcr_pkg::OP_CLEAR: begin
              cmd.take_clear = 1'b1;
              cmd.load_ack   = 1'b1;
            end
            clcr_pkg::OP_READ_LINE: begin
              cmd.take_line  = 1'b1;
              cmd.load_empty = st.miss;
            end
            clcr_pkg::OP_READ_PART: begin
              cmd.take_part  = 1'b1;
              cmd.load_empty = st.plen_zero;
            end
            default: cmd = '0;
          endcase
        end
      end
      clcr_pkg::S_LEN: cmd.load_len = 1'b1;
      clcr_pkg::S_NULL: cmd.load_empty = st.out_free;
      clcr_pkg::S_EMIT: begin
        cmd.load_char = st.out_free;
        cmd.idx_inc   = st.out_free && !st.last_char;
      end
      default: cmd = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == clcr_pkg::S_IDLE)
    else $error("input taken outside idle");
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_ack, cmd.load_empty, cmd.load_char}))
    else $error("two result loads at once");
  a_fetch_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == clcr_pkg::S_FETCH |=> state_r == clcr_pkg::S_EMIT)
    else $error("fetch not followed by emit");
`endif

endmodule

// ===== hdl/clcr_datapath.sv =====
// ----------------------------------------------------------------------------
// clcr_datapath
// Escape filter, line memories, ring pointers, status counters and output
// register.
// ----------------------------------------------------------------------------
module clcr_datapath #(
  parameter int LINES = 16,
  parameter int COLS  = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  clcr_pkg::ctrl_cmd_t                 cmd,
  output clcr_pkg::dp_stat_t                  st,
  input  logic [clcr_pkg::BYTE_W-1:0]         in_char,
  input  logic [clcr_pkg::BACK_W-1:0]         in_back,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [clcr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);

  localparam int RW    = $clog2(LINES + 1);
  localparam int CW    = $clog2(COLS);
  localparam int CMPW  = (RW > clcr_pkg::BACK_W) ? RW : clcr_pkg::BACK_W;
  localparam int MEM_D = (LINES + 1) * (2 ** CW);
  localparam int PADW  = clcr_pkg::OUT_DATA_W - clcr_pkg::CHAR_W - clcr_pkg::CNT_W
                         - clcr_pkg::LEN_W - clcr_pkg::DROP_W - clcr_pkg::GEN_W;

  logic [clcr_pkg::CHAR_W-1:0] line_mem [MEM_D];
  logic [clcr_pkg::LEN_W-1:0]  len_mem  [LINES+1];

  logic [RW-1:0]                wr_row_r, wr_row_nxt;
  logic [RW-1:0]                stored_r, stored_nxt;
  logic [clcr_pkg::LEN_W-1:0]   plen_r, plen_nxt;
  logic [clcr_pkg::DROP_W-1:0]  drop_r, drop_nxt;
  logic [clcr_pkg::GEN_W-1:0]   gen_r, gen_nxt;
  clcr_pkg::esc_t               esc_r, esc_nxt;

  logic [RW-1:0]                rd_row_r;
  logic [CW-1:0]                idx_r;
  logic [clcr_pkg::LEN_W-1:0]   rd_len_r;
  logic [clcr_pkg::LEN_W-1:0]   len_q_r;
  logic [clcr_pkg::CHAR_W-1:0]  rdata_r;

  logic                         out_valid_r;
  logic [clcr_pkg::CHAR_W-1:0]  out_char_r;
  logic                         out_last_r;
  logic                         out_empty_r;
  logic [clcr_pkg::CNT_W-1:0]   out_cnt_r;
  logic [clcr_pkg::LEN_W-1:0]   out_plen_r;
  logic [clcr_pkg::DROP_W-1:0]  out_drop_r;
  logic [clcr_pkg::GEN_W-1:0]   out_gen_r;

  logic                         f_store, f_commit, f_drop;
  logic [clcr_pkg::BYTE_W-1:0]  f_char;
  logic [RW:0]                  age_sum;
  logic [RW-1:0]                age_row;
  logic                         out_load;

  // escape filter
  always_comb begin
    esc_nxt  = esc_r;
    f_store  = 1'b0;
    f_commit = 1'b0;
    f_drop   = 1'b0;
    f_char   = in_char;
    unique case (esc_r)
      clcr_pkg::ESC_SEEN: begin
        esc_nxt = (in_char == clcr_pkg::CH_LBRACK) ? clcr_pkg::ESC_CSI : clcr_pkg::ESC_NORMAL;
      end
      clcr_pkg::ESC_CSI: begin
        if (in_char >= clcr_pkg::CH_FIN_LO && in_char <= clcr_pkg::CH_FIN_HI) begin
          esc_nxt = clcr_pkg::ESC_NORMAL;
        end
      end
      default: begin
        esc_nxt = clcr_pkg::ESC_NORMAL;
        priority if (in_char == clcr_pkg::CH_ESC) begin
          esc_nxt = clcr_pkg::ESC_SEEN;
        end else if (in_char == clcr_pkg::CH_CR) begin
          f_store = 1'b0;
        end else if (in_char == clcr_pkg::CH_LF) begin
          f_commit = 1'b1;
        end else begin
          if (in_char == clcr_pkg::CH_TAB) begin
            f_char = clcr_pkg::CH_SPACE;
          end else if (in_char < clcr_pkg::CH_SPACE || in_char > clcr_pkg::CH_FIN_HI) begin
            f_char = clcr_pkg::CH_QMARK;
          end
          if (plen_r < clcr_pkg::LEN_W'(COLS)) begin
            f_store = 1'b1;
          end else if (drop_r != clcr_pkg::DROP_MAX) begin
            f_drop = 1'b1;
          end
        end
      end
    endcase
  end

  // status update
  always_comb begin
    wr_row_nxt = wr_row_r;
    stored_nxt = stored_r;
    plen_nxt   = plen_r;
    drop_nxt   = drop_r;
    gen_nxt    = gen_r;
    if (cmd.take_put) begin
      if (f_commit) begin
        wr_row_nxt = (wr_row_r == RW'(LINES)) ? '0 : wr_row_r + RW'(1);
        if (stored_r != RW'(LINES)) begin
          stored_nxt = stored_r + RW'(1);
        end
        plen_nxt = '0;
        drop_nxt = '0;
        gen_nxt  = gen_r + clcr_pkg::GEN_W'(1);
      end
      if (f_store) begin
        plen_nxt = plen_r + clcr_pkg::LEN_W'(1);
      end
      if (f_drop) begin
        drop_nxt = drop_r + clcr_pkg::DROP_W'(1);
      end
    end else if (cmd.take_clear) begin
      stored_nxt = '0;
      plen_nxt   = '0;
      drop_nxt   = '0;
      gen_nxt    = gen_r + clcr_pkg::GEN_W'(1);
    end
  end

  // row of the committed line at the requested age
  always_comb begin
    age_sum = {1'b0, wr_row_r} + (RW+1)'(LINES) - (RW+1)'(in_back);
    if (age_sum >= (RW+1)'(LINES + 1)) begin
      age_row = RW'(age_sum - (RW+1)'(LINES + 1));
    end else begin
      age_row = age_sum[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_row_r <= '0;
      stored_r <= '0;
      plen_r   <= '0;
      drop_r   <= '0;
      gen_r    <= '0;
      esc_r    <= clcr_pkg::ESC_NORMAL;
    end else begin
      wr_row_r <= wr_row_nxt;
      stored_r <= stored_nxt;
      plen_r   <= plen_nxt;
      drop_r   <= drop_nxt;
      gen_r    <= gen_nxt;
      if (cmd.take_put) begin
        esc_r <= esc_nxt;
      end else if (cmd.take_clear) begin
        esc_r <= clcr_pkg::ESC_NORMAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_put && f_store) begin
      line_mem[{wr_row_r, plen_r[CW-1:0]}] <= f_char[clcr_pkg::CHAR_W-1:0];
    end
    rdata_r <= line_mem[{rd_row_r, idx_r}];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_put && f_commit) begin
      len_mem[wr_row_r] <= plen_r;
    end
    len_q_r <= len_mem[rd_row_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_line) begin
      rd_row_r <= age_row;
    end else if (cmd.take_part) begin
      rd_row_r <= wr_row_r;
      rd_len_r <= plen_r;
    end else if (cmd.load_len) begin
      rd_len_r <= len_q_r;
    end
    if (cmd.take_line || cmd.take_part) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  assign st.out_free  = !out_valid_r || out_tready;
  assign st.miss      = CMPW'(in_back) >= CMPW'(stored_r);
  assign st.plen_zero = plen_r == '0;
  assign st.len_zero  = len_q_r == '0;
  assign st.last_char = (clcr_pkg::LEN_W'(idx_r) + clcr_pkg::LEN_W'(1)) == rd_len_r;

  assign out_load = cmd.load_ack || cmd.load_empty || cmd.load_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r  <= cmd.load_char ? rdata_r : '0;
      out_last_r  <= cmd.load_char ? st.last_char : 1'b1;
      out_empty_r <= cmd.load_empty;
      out_cnt_r   <= clcr_pkg::CNT_W'(stored_nxt);
      out_plen_r  <= plen_nxt;
      out_drop_r  <= drop_nxt;
      out_gen_r   <= gen_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;
  assign out_tdata  = {{PADW{1'b0}}, out_gen_r, out_drop_r, out_plen_r, out_cnt_r, out_char_r};

`ifndef ASSERT_OFF
  a_plen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= clcr_pkg::LEN_W'(COLS))
    else $error("partial line past column limit");
  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (stored_r <= RW'(LINES)) && (wr_row_r <= RW'(LINES)))
    else $error("ring pointer out of range");
  a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_clear |=> (plen_r == '0) && (stored_r == '0) && (drop_r == '0))
    else $error("clear did not reset the ring");
  a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_char_r == '0) && out_last_r)
    else $error("empty result carries a character");
  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_clear || (cmd.take_put && f_commit)) |=> gen_r == $past(gen_r) + 32'd1)
    else $error("change counter not bumped");
`endif

endmodule

// ===== hdl/console_line_capture_ring.sv =====
// ----------------------------------------------------------------------------
// console_line_capture_ring
// Console byte capture with ANSI CSI stripping into a ring of text lines.
// ----------------------------------------------------------------------------
// Put and clear items give one result each, so a stream of console bytes runs
// at one byte per cycle while the output is drained. A read of the partial
// line passes a fetch state and an emit state for each character; a read of a
// committed line first passes a wait and a length state. A missing line or an
// empty partial line loads its result in the cycle the item is taken; an empty
// committed line answers from the null state after the length fetch, once the
// output is free. The line memory has one write port and one registered read
// port, read in the fetch state. The memory holds LINES + 1 rows of COLS
// characters: the partial line is built in place in the row after the newest
// line, so a line feed moves no characters but writes the length table and
// advances the row pointer. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module console_line_capture_ring #(
  parameter int LINES = 16,
  parameter int COLS  = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // char_in[7:0], line_back[11:8], zero fill above
  input  logic [clcr_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode[1:0]
  input  logic [clcr_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // char_out[6:0], line_count[11:7], partial_len[18:12], dropped[34:19],
  // generation[66:35], zero fill above
  output logic [clcr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  // empty_res[0]
  output logic                                out_tuser
);

  clcr_pkg::ctrl_cmd_t cmd;
  clcr_pkg::dp_stat_t  st;

  clcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  clcr_datapath #(
    .LINES (LINES),
    .COLS  (COLS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_char    (in_tdata[7:0]),
    .in_back    (in_tdata[11:8]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
